[rtl/number_to_english_words_core_macros.svh]
`ifndef NUMBER_TO_ENGLISH_WORDS_CORE_MACROS_SVH
`define NUMBER_TO_ENGLISH_WORDS_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define NTEW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ntew: same-cycle check failed");

// next-cycle implication
`define NTEW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ntew: next-cycle check failed");

`endif

[rtl/ntew_pkg.sv]
package ntew_pkg;

    localparam int VALUE_W = 31;
    localparam int CODE_W  = 5;
    localparam int DIGITS  = 10;
    localparam int BCD_W   = 4 * DIGITS;
    localparam int BIT_W   = $clog2(VALUE_W);
    localparam int PC_W    = 4;

    localparam logic [CODE_W-1:0] CODE_ZERO    = 5'd0;
    localparam logic [CODE_W-1:0] CODE_TEEN    = 5'd10;
    localparam logic [CODE_W-1:0] CODE_TENS    = 5'd18;  // Twenty sits at 18 + 2
    localparam logic [CODE_W-1:0] CODE_HUNDRED = 5'd28;

    typedef logic [2:0]      src_t;
    typedef logic [1:0]      op_t;
    typedef logic [2:0]      jc_t;
    typedef logic [PC_W-1:0] pc_t;

    // word source for a step
    localparam src_t SRC_NONE    = 3'd0;
    localparam src_t SRC_HUND    = 3'd1;
    localparam src_t SRC_HUNDRED = 3'd2;
    localparam src_t SRC_REST    = 3'd3;
    localparam src_t SRC_ONES    = 3'd4;
    localparam src_t SRC_SCALE   = 3'd5;
    localparam src_t SRC_ZERO    = 3'd6;

    // datapath operation
    localparam op_t OP_NOP   = 2'd0;
    localparam op_t OP_LOAD  = 2'd1;
    localparam op_t OP_SHIFT = 2'd2;
    localparam op_t OP_GDEC  = 2'd3;

    // jump conditions
    localparam jc_t JC_NEVER    = 3'd0;
    localparam jc_t JC_ALWAYS   = 3'd1;
    localparam jc_t JC_NOT_FIRE = 3'd2;
    localparam jc_t JC_BIT_MORE = 3'd3;
    localparam jc_t JC_VAL_ZERO = 3'd4;
    localparam jc_t JC_GRP_ZERO = 3'd5;
    localparam jc_t JC_GRP_LAST = 3'd6;

    typedef struct packed {
        src_t src;
        op_t  op;
        logic flush;
        jc_t  jc;
        pc_t  target;
    } ctl_t;

    typedef struct packed {
        logic fire;
        logic bit_more;
        logic val_zero;
        logic grp_zero;
        logic grp_last;
        logic stall;
    } stat_t;

endpackage

[rtl/ntew_in_if.sv]
interface ntew_in_if;
    logic                         valid;
    logic                         ready;
    logic [ntew_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

[rtl/ntew_out_if.sv]
interface ntew_out_if;
    logic                        valid;
    logic                        ready;
    logic [ntew_pkg::CODE_W-1:0] word_code;
    logic                        last_word;

    modport source (output valid, output word_code, output last_word, input ready);
    modport sink   (input valid, input word_code, input last_word, output ready);
endinterface

[rtl/ntew_seq.sv]
module ntew_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  ntew_pkg::stat_t stat,
    output ntew_pkg::ctl_t  ctl
);
    import ntew_pkg::*;

    localparam pc_t STEP_WAIT  = 4'd0;
    localparam pc_t STEP_SHIFT = 4'd1;
    localparam pc_t STEP_CHKZ  = 4'd2;
    localparam pc_t STEP_GROUP = 4'd3;
    localparam pc_t STEP_HUND  = 4'd4;
    localparam pc_t STEP_HWORD = 4'd5;
    localparam pc_t STEP_REST  = 4'd6;
    localparam pc_t STEP_ONES  = 4'd7;
    localparam pc_t STEP_SCALE = 4'd8;
    localparam pc_t STEP_LOOP  = 4'd9;
    localparam pc_t STEP_ZERO  = 4'd10;
    localparam pc_t STEP_FLUSH = 4'd11;

    pc_t  pc_reg;
    pc_t  pc_next;
    logic take;

    // control store
    function automatic ctl_t rom_word(input pc_t a);
        ctl_t w;
        w = '{src: SRC_NONE, op: OP_NOP, flush: 1'b0, jc: JC_NEVER, target: STEP_WAIT};
        case (a)
            STEP_WAIT:
            begin
                w.op     = OP_LOAD;
                w.jc     = JC_NOT_FIRE;
                w.target = STEP_WAIT;
            end
            STEP_SHIFT:
            begin
                w.op     = OP_SHIFT;
                w.jc     = JC_BIT_MORE;
                w.target = STEP_SHIFT;
            end
            STEP_CHKZ:
            begin
                w.jc     = JC_VAL_ZERO;
                w.target = STEP_ZERO;
            end
            STEP_GROUP:
            begin
                w.jc     = JC_GRP_ZERO;
                w.target = STEP_SCALE;
            end
            STEP_HUND:  w.src = SRC_HUND;
            STEP_HWORD: w.src = SRC_HUNDRED;
            STEP_REST:  w.src = SRC_REST;
            STEP_ONES:  w.src = SRC_ONES;
            STEP_SCALE:
            begin
                // scale word only if the group was non-zero
                w.src    = SRC_NONE;
                w.op     = OP_GDEC;
                w.jc     = JC_GRP_LAST;
                w.target = STEP_FLUSH;
            end
            STEP_LOOP:
            begin
                w.jc     = JC_ALWAYS;
                w.target = STEP_GROUP;
            end
            STEP_ZERO:  w.src = SRC_ZERO;
            STEP_FLUSH:
            begin
                w.flush  = 1'b1;
                w.jc     = JC_ALWAYS;
                w.target = STEP_WAIT;
            end
            default:
            begin
                w.jc     = JC_ALWAYS;
                w.target = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

    always_comb
    begin
        ctl = rom_word(pc_reg);
        // a zero group jumps straight here and must not name its scale
        if (pc_reg == STEP_SCALE)
        begin
            ctl.src = stat.grp_zero ? SRC_NONE : SRC_SCALE;
        end
    end

    always_comb
    begin
        case (ctl.jc)
            JC_NEVER:    take = 1'b0;
            JC_ALWAYS:   take = 1'b1;
            JC_NOT_FIRE: take = !stat.fire;
            JC_BIT_MORE: take = stat.bit_more;
            JC_VAL_ZERO: take = stat.val_zero;
            JC_GRP_ZERO: take = stat.grp_zero;
            JC_GRP_LAST: take = stat.grp_last;
            default:     take = 1'b0;
        endcase
    end

    always_comb
    begin
        if (stat.stall)
        begin
            pc_next = pc_reg;
        end
        else if (take)
        begin
            pc_next = ctl.target;
        end
        else
        begin
            pc_next = pc_reg + pc_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

[rtl/ntew_dp.sv]
module ntew_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ntew_pkg::ctl_t               ctl,
    output ntew_pkg::stat_t              stat,
    input  logic                         in_valid,
    input  logic [ntew_pkg::VALUE_W-1:0] in_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ntew_pkg::CODE_W-1:0]  out_code,
    output logic                         out_last
);
    import ntew_pkg::*;

    logic [VALUE_W-1:0] val_reg, val_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [BCD_W-1:0]   bcd_adj;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic [1:0]         gi_reg, gi_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [CODE_W-1:0]  pend_code_reg, pend_code_next;
    logic               out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]  out_code_reg, out_code_next;
    logic               out_last_reg, out_last_next;

    logic [11:0]        grp;
    logic [3:0]         hund, tens, ones;
    logic               emit_en;
    logic [CODE_W-1:0]  emit_code;
    logic               fire, out_free, push, stall;

    assign fire = in_valid && (ctl.op == OP_LOAD);

    // shift-and-add-3, one input bit per step
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                           : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        case (gi_reg)
            2'd0:    grp = bcd_reg[11:0];
            2'd1:    grp = bcd_reg[23:12];
            2'd2:    grp = bcd_reg[35:24];
            default: grp = {8'd0, bcd_reg[39:36]};
        endcase
    end

    assign hund = grp[11:8];
    assign tens = grp[7:4];
    assign ones = grp[3:0];

    always_comb
    begin
        emit_en   = 1'b0;
        emit_code = CODE_ZERO;
        case (ctl.src)
            SRC_HUND:
            begin
                emit_en   = (hund != 4'd0);
                emit_code = {1'b0, hund};
            end
            SRC_HUNDRED:
            begin
                emit_en   = (hund != 4'd0);
                emit_code = CODE_HUNDRED;
            end
            SRC_REST:
            begin
                emit_en = (tens != 4'd0) || (ones != 4'd0);
                if (tens >= 4'd2)
                begin
                    emit_code = CODE_TENS + {1'b0, tens};
                end
                else if (tens == 4'd1)
                begin
                    emit_code = CODE_TEEN + {1'b0, ones};
                end
                else
                begin
                    emit_code = {1'b0, ones};
                end
            end
            SRC_ONES:
            begin
                emit_en   = (tens >= 4'd2) && (ones != 4'd0);
                emit_code = {1'b0, ones};
            end
            SRC_SCALE:
            begin
                emit_en   = (gi_reg != 2'd0);
                emit_code = CODE_HUNDRED + {3'd0, gi_reg};
            end
            SRC_ZERO:
            begin
                emit_en   = 1'b1;
                emit_code = CODE_ZERO;
            end
            default:
            begin
                emit_en   = 1'b0;
                emit_code = CODE_ZERO;
            end
        endcase
    end

    // one word is held back so the final one can be flagged on flush
    assign out_free = !out_valid_reg || out_ready;
    assign push     = (emit_en && pend_valid_reg) || ctl.flush;
    assign stall    = push && !out_free;

    always_comb
    begin
        val_next        = val_reg;
        bcd_next        = bcd_reg;
        bit_next        = bit_reg;
        gi_next         = gi_reg;
        pend_valid_next = pend_valid_reg;
        pend_code_next  = pend_code_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_code_next   = out_code_reg;
        out_last_next   = out_last_reg;

        if (!stall)
        begin
            case (ctl.op)
                OP_LOAD:
                begin
                    if (fire)
                    begin
                        val_next = in_value;
                        bcd_next = '0;
                        bit_next = BIT_W'(VALUE_W - 1);
                        gi_next  = 2'd3;
                    end
                end
                OP_SHIFT:
                begin
                    bcd_next = {bcd_adj[BCD_W-2:0], val_reg[VALUE_W-1]};
                    val_next = {val_reg[VALUE_W-2:0], 1'b0};
                    bit_next = bit_reg - BIT_W'(1);
                end
                OP_GDEC: gi_next = gi_reg - 2'd1;
                default: ;
            endcase

            if (push)
            begin
                out_valid_next = 1'b1;
                out_code_next  = pend_code_reg;
                out_last_next  = ctl.flush;
            end
            if (ctl.flush)
            begin
                pend_valid_next = 1'b0;
            end
            else if (emit_en)
            begin
                pend_valid_next = 1'b1;
                pend_code_next  = emit_code;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg       <= val_next;
        bcd_reg       <= bcd_next;
        bit_reg       <= bit_next;
        gi_reg        <= gi_next;
        pend_code_reg <= pend_code_next;
        out_code_reg  <= out_code_next;
        out_last_reg  <= out_last_next;
    end

    assign stat.fire     = fire;
    assign stat.bit_more = (bit_reg != '0);
    assign stat.val_zero = (bcd_reg == '0);
    assign stat.grp_zero = (grp == 12'd0);
    assign stat.grp_last = (gi_reg == 2'd0);
    assign stat.stall    = stall;

    assign out_valid = out_valid_reg;
    assign out_code  = out_code_reg;
    assign out_last  = out_last_reg;

endmodule

[rtl/number_to_english_words_core.sv]
// One value at a time. The 31-step binary-to-BCD loop of the microcode runs first;
// each three-digit group then costs up to 7 control steps, at most one word per
// step. Output stalls hold the step.
// Reset: step counter returns to the wait step, held-back and output words drop.
`include "number_to_english_words_core_macros.svh"

module number_to_english_words_core (
    input  logic            clk,
    input  logic            rst_n,
    ntew_in_if.sink         num,
    ntew_out_if.source      words
);
    import ntew_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    ntew_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    ntew_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .in_valid  (num.valid),
        .in_value  (num.value),
        .out_valid (words.valid),
        .out_ready (words.ready),
        .out_code  (words.word_code),
        .out_last  (words.last_word)
    );

    assign num.ready = (ctl.op == OP_LOAD);

    // a held step must not move the program
    `NTEW_ASSERT_NEXT(a_stall_holds_step, stat.stall, $stable(ctl))
    // no second value is taken right behind the first
    `NTEW_ASSERT_NEXT(a_one_in_flight, num.valid && num.ready, !num.ready)
    // a waiting word stays put until taken
    `NTEW_ASSERT_NEXT(a_out_hold, words.valid && !words.ready, words.valid && $stable(words.word_code) && $stable(words.last_word))

endmodule

[sim/number_to_english_words_core_tb.sv]
module number_to_english_words_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ntew_pkg::*;

    localparam logic [CODE_W-1:0] CODE_THOUSAND = 5'd29;  // Million and Billion follow
    localparam longint unsigned VALUE_MAX = 64'h7FFF_FFFF;
    localparam int RANDOM_VALUES = 136;
    localparam int PRESSURE_WORD = 300;
    localparam int PRESSURE_CYCLES = 500;
    localparam int DRAIN_CYCLES = 100;
    localparam int NUM_DIRECTED = 24;

    localparam int unsigned DIRECTED[NUM_DIRECTED] = '{
        0, 1, 9, 10, 11, 15, 19, 20, 21, 99, 100, 101, 110, 119, 120, 999,
        1000, 1001, 12345, 1000000, 1000010, 1000000000, 1234567891, 2147483647
    };

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } word_t;

    logic clk = 1'b0;
    logic rst_n;

    ntew_in_if  num_if();
    ntew_out_if words_if();

    logic [VALUE_W-1:0] pending_values[$];
    word_t              expected_words[$];
    int                 values_taken = 0;
    int                 words_taken = 0;
    int                 error_count = 0;
    int unsigned        send_gap;
    int unsigned        recv_stall;

    number_to_english_words_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .num   (num_if),
        .words (words_if)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        error_count++;
    endtask

    // Queue up the word run that names v, last word flagged.
    function automatic void name_value(input logic [VALUE_W-1:0] v);
        logic [CODE_W-1:0] run[$];
        int unsigned       groups[4];
        int unsigned       rem;
        int unsigned       grp;
        int unsigned       hund;
        int unsigned       rest;
        rem = v;
        if (v == '0)
            run.push_back(CODE_ZERO);
        for (int g = 0; g < 4; g++)
        begin
            groups[g] = rem % 1000;
            rem       = rem / 1000;
        end
        for (int g = 3; g >= 0; g--)
        begin
            grp  = groups[g];
            hund = grp / 100;
            rest = grp % 100;
            if (grp != 0)
            begin
                if (hund != 0)
                begin
                    run.push_back(CODE_W'(hund));
                    run.push_back(CODE_HUNDRED);
                end
                if (rest >= 20)
                begin
                    run.push_back(CODE_TENS + CODE_W'(rest / 10));
                    if (rest % 10 != 0)
                        run.push_back(CODE_W'(rest % 10));
                end
                else if (rest != 0)
                    run.push_back(CODE_W'(rest));  // ones and teens share their code
                if (g != 0)
                    run.push_back(CODE_THOUSAND + CODE_W'(g - 1));
            end
        end
        foreach (run[i])
            expected_words.push_back('{code: run[i], last: 1'(i == run.size() - 1)});
    endfunction

    function automatic int unsigned pick_group();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return $urandom_range(1, 9);
            2:       return $urandom_range(10, 19);
            3:       return $urandom_range(20, 99);
            4:       return 100 * $urandom_range(1, 9) + $urandom_range(0, 19);
            default: return $urandom_range(0, 999);
        endcase
    endfunction

    // Mostly values built group by group so teens, tens and skipped groups show up often.
    function automatic logic [VALUE_W-1:0] random_value();
        longint unsigned v;
        if ($urandom_range(0, 3) == 0)
            return VALUE_W'($urandom() >> $urandom_range(0, 31));
        v = longint'($urandom_range(0, 2)) * 1000000000
            + longint'(pick_group()) * 1000000
            + longint'(pick_group()) * 1000
            + longint'(pick_group());
        if (v > VALUE_MAX)
            v = v - 1000000000;
        return VALUE_W'(v);
    endfunction

    function automatic int unsigned draw_gap(input bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // value sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_if.valid <= 1'b0;
            num_if.value <= '0;
            send_gap     <= 0;
        end
        else
        begin
            if (num_if.valid && num_if.ready)
            begin
                name_value(num_if.value);
                values_taken <= values_taken + 1;
            end
            if (!num_if.valid || num_if.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap     <= send_gap - 1;
                    num_if.valid <= 1'b0;
                end
                else if (pending_values.size() != 0)
                begin
                    num_if.valid <= 1'b1;
                    num_if.value <= pending_values.pop_front();
                    send_gap     <= draw_gap((values_taken / 30) % 3 == 1);
                end
                else
                    num_if.valid <= 1'b0;
            end
        end
    end

    // word receiver and checker
    always @(posedge clk or negedge rst_n)
    begin : word_check
        word_t       want;
        int unsigned stall;
        if (!rst_n)
        begin
            words_if.ready <= 1'b0;
            recv_stall     <= 0;
        end
        else if (words_if.valid && words_if.ready)
        begin
            if (expected_words.size() == 0)
                report_mismatch($sformatf("word %0d: code %0d last %0b with nothing pending",
                                          words_taken, words_if.word_code, words_if.last_word));
            else
            begin
                want = expected_words.pop_front();
                if (words_if.word_code !== want.code)
                    report_mismatch($sformatf("word %0d: code %0d, want %0d",
                                              words_taken, words_if.word_code, want.code));
                if (words_if.last_word !== want.last)
                    report_mismatch($sformatf("word %0d: last_word %0b, want %0b",
                                              words_taken, words_if.last_word, want.last));
            end
            words_taken <= words_taken + 1;
            // one long hold-off lets the input side back up
            if (words_taken + 1 == PRESSURE_WORD)
                stall = PRESSURE_CYCLES;
            else
                stall = draw_gap((words_taken / 200) % 3 == 1);
            recv_stall     <= stall;
            words_if.ready <= (stall == 0);
        end
        else if (recv_stall != 0)
        begin
            recv_stall     <= recv_stall - 1;
            words_if.ready <= (recv_stall == 1);
        end
        else
            words_if.ready <= ((words_taken / 200) % 3 == 1) || ($urandom_range(0, 7) != 0);
    end

    initial
    begin
        rst_n = 1'b0;
        for (int i = 0; i < NUM_DIRECTED; i++)
            pending_values.push_back(VALUE_W'(DIRECTED[i]));
        repeat (RANDOM_VALUES)
            pending_values.push_back(random_value());
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(negedge clk);
        while (pending_values.size() != 0 || num_if.valid || expected_words.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/ntew_pkg.sv
rtl/ntew_in_if.sv
rtl/ntew_out_if.sv
rtl/ntew_seq.sv
rtl/ntew_dp.sv
rtl/number_to_english_words_core.sv
sim/number_to_english_words_core_tb.sv
